@@ sv/piece_table_span_editor_top_assert.svh @@
// ----------------------------------------------------------------------------
// Piece table span editor assertion macros
// Concurrent checks for the editor; the bodies vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PIECE_TABLE_SPAN_EDITOR_TOP_ASSERT_SVH
`define PIECE_TABLE_SPAN_EDITOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pts check failed");
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pts check failed");
`else
`define PTS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Piece table span editor package
// Sizes, piece record, cell controls and the per-piece edit function.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;
   localparam int MaxPieces = 32;
   localparam int PosBits = 20;
   localparam int StepBits = $clog2(MaxPieces);
   localparam int CountBits = $clog2(MaxPieces + 3);

   typedef logic [PosBits-1:0] pos_type;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef struct packed {
      logic    valid;
      logic    from_append;
      pos_type start;
      pos_type size;
   } piece_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD,
      CELL_SWAP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0] cnt;
      piece_type  p0;
      piece_type  p1;
      piece_type  p2;
      logic       placed;
   } edit_out_type;

   function automatic edit_out_type edit_piece(
      input logic      is_ins,
      input pos_type   pos,
      input pos_type   len,
      input pos_type   lo,
      input pos_type   hi,
      input pos_type   app,
      input pos_type   a,
      input logic      placed,
      input piece_type head
   );
      edit_out_type   r;
      logic [PosBits:0] at;
      piece_type      fresh;
      piece_type      left_part;
      piece_type      right_part;
      r = '0;
      r.placed = placed;
      at = {1'b0, a} + {1'b0, head.size};
      fresh = '{valid: 1'b1, from_append: 1'b1, start: app, size: len};
      left_part = '{valid: 1'b1, from_append: head.from_append, start: head.start,
                    size: '0};
      right_part = left_part;
      if (!head.valid) begin
         if (is_ins && !placed) begin
            r.cnt = 2'd1;
            r.p0 = fresh;
            r.placed = 1'b1;
         end
      end else if (is_ins) begin
         if (!placed && ({1'b0, pos} < at)) begin
            if (pos == a) begin
               r.cnt = 2'd2;
               r.p0 = fresh;
               r.p1 = head;
            end else begin
               left_part.size = pos - a;
               right_part.start = head.start + (pos - a);
               right_part.size = at[PosBits-1:0] - pos;
               r.cnt = 2'd3;
               r.p0 = left_part;
               r.p1 = fresh;
               r.p2 = right_part;
            end
            r.placed = 1'b1;
         end else begin
            r.cnt = 2'd1;
            r.p0 = head;
         end
      end else begin
         if ((at <= {1'b0, lo}) || (a >= hi)) begin
            r.cnt = 2'd1;
            r.p0 = head;
         end else begin
            left_part.size = lo - a;
            right_part.start = head.start + (hi - a);
            right_part.size = at[PosBits-1:0] - hi;
            if (a < lo) begin
               r.p0 = left_part;
               r.cnt = 2'd1;
               if (at > {1'b0, hi}) begin
                  r.p1 = right_part;
                  r.cnt = 2'd2;
               end
            end else if (at > {1'b0, hi}) begin
               r.p0 = right_part;
               r.cnt = 2'd1;
            end
         end
      end
      return r;
   endfunction
endpackage
`default_nettype wire

@@ sv/pts_channels.sv @@
// ----------------------------------------------------------------------------
// Piece table span editor channels
// Valid/ready interfaces for requests, results and the register write port.
// ----------------------------------------------------------------------------
`default_nettype none
interface pts_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [pts_pkg::PosBits-1:0]   position;
   logic [pts_pkg::PosBits-1:0]   span_length;
   modport source (output valid, action, position, span_length, input ready);
   modport sink (input valid, action, position, span_length, output ready);
endinterface

interface pts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          from_append;
   logic [pts_pkg::PosBits-1:0]   span_start;
   logic [pts_pkg::PosBits-1:0]   span_size;
   logic                          entry_valid;
   logic [pts_pkg::PosBits-1:0]   total_length;
   logic                          rejected;
   logic                          last;
   modport source (output valid, from_append, span_start, span_size, entry_valid,
                   total_length, rejected, last, input ready);
   modport sink (input valid, from_append, span_start, span_size, entry_valid,
                 total_length, rejected, last, output ready);
endinterface

interface pts_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pts_pkg::PosBits-1:0]   original_size;
   modport source (output valid, original_size, input ready);
   modport sink (input valid, original_size, output ready);
endinterface
`default_nettype wire

@@ sv/pts_cell.sv @@
// ----------------------------------------------------------------------------
// Piece table cell
// Holds one piece; shifts toward the head, loads, or swaps with a neighbor
// to push empty slots toward the tail.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pts_pkg::cell_ctl_type ctl,
   input  wire logic                  odd_pos,
   input  wire pts_pkg::piece_type    left_in,
   input  wire pts_pkg::piece_type    right_in,
   input  wire pts_pkg::piece_type    load_in,
   output pts_pkg::piece_type         piece
);
   import pts_pkg::*;

   piece_type piece_ff;
   piece_type piece_in;

   always_comb begin
      piece_in = piece_ff;
      unique case (ctl.op)
         CELL_HOLD:  piece_in = piece_ff;
         CELL_SHIFT: piece_in = right_in;
         CELL_LOAD:  piece_in = load_in;
         CELL_SWAP: begin
            if (odd_pos == ctl.phase) begin
               if (!piece_ff.valid && right_in.valid) piece_in = right_in;
            end else begin
               if (!left_in.valid && piece_ff.valid) piece_in = '0;
            end
         end
         default: piece_in = piece_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_ff.valid <= 1'b0;
      end else begin
         piece_ff.valid <= piece_in.valid;
      end
      piece_ff.from_append <= piece_in.from_append;
      piece_ff.start <= piece_in.start;
      piece_ff.size <= piece_in.size;
   end

   assign piece = piece_ff;
endmodule
`default_nettype wire

@@ sv/piece_table_span_editor_top.sv @@
// ----------------------------------------------------------------------------
// Piece table span editor
// Keeps the piece list in a row of cells and dumps it after every request.
// ----------------------------------------------------------------------------
// The table lives in MaxPieces cells that rotate one step per cycle in the
// scan, rewrite and dump passes; in the dump a step with a valid head piece
// waits while the result side stalls. A start request loads the original
// piece into the first cell as it is taken. An insert or delete that changes
// the table makes three passes: a scan that counts the new pieces and checks
// room, a rewrite that edits each piece as it leaves the head and re-enters at
// the tail, and a compaction by neighbor swaps. The dump then sends each valid
// piece (a single entry for an empty table). A start, a no-op or an overflowing
// insert goes straight to the dump; an edit refused for lack of room skips the
// rewrite and compaction. A new request is taken only once the dump is done.
`default_nettype none
`include "piece_table_span_editor_top_assert.svh"
module piece_table_span_editor_top (
   input  wire logic     clock,
   input  wire logic     reset,
   pts_req_if.sink       req_chan,
   pts_rsp_if.source     rsp_chan,
   pts_csr_if.sink       csr_chan
);
   import pts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REWRITE,
      ST_COMPACT,
      ST_DUMP
   } state_type;

   state_type              state_ff;
   logic [StepBits-1:0]    step_ff;
   logic [CountBits-1:0]   count_ff;
   logic [CountBits-1:0]   n_ff;
   logic [CountBits-1:0]   emitted_ff;
   pos_type                a_ff;
   logic                   placed_ff;
   logic                   ins_ff;
   pos_type                pos_ff;
   pos_type                len_ff;
   pos_type                lo_ff;
   pos_type                hi_ff;
   pos_type                doc_ff;
   pos_type                app_ff;
   pos_type                orig_ff;
   logic                   rej_ff;
   piece_type              q_ff [2];
   logic [1:0]             qn_ff;
   logic                   rsp_valid_ff;
   piece_type              out_piece_ff;
   pos_type                out_total_ff;
   logic                   out_rej_ff;
   logic                   out_last_ff;

   piece_type              cell_q [MaxPieces];
   piece_type              head;
   piece_type              tail;
   piece_type              start_piece;
   cell_ctl_type           ctl;
   edit_out_type           eo;
   piece_type              comb [4];
   logic [2:0]             total;
   logic [CountBits-1:0]   n_in;
   logic [CountBits-1:0]   n_total;
   pos_type                a_in;
   logic                   req_fire;
   logic                   out_free;
   logic                   last_step;
   logic                   dump_emit;
   logic                   dump_move;
   logic                   rsp_load;
   pos_type                pos_c;
   logic [PosBits:0]       del_sum;
   pos_type                hi_c;
   logic [PosBits:0]       app_sum;
   logic [PosBits:0]       doc_sum;
   logic                   ins_over;
   state_type              idle_next;

   assign head = cell_q[0];
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign last_step = (step_ff == StepBits'(MaxPieces - 1));

   assign pos_c = (req_chan.position > doc_ff) ? doc_ff : req_chan.position;
   assign del_sum = {1'b0, pos_c} + {1'b0, req_chan.span_length};
   assign hi_c = (del_sum > {1'b0, doc_ff}) ? doc_ff : del_sum[PosBits-1:0];
   assign app_sum = {1'b0, app_ff} + {1'b0, req_chan.span_length};
   assign doc_sum = {1'b0, doc_ff} + {1'b0, req_chan.span_length};
   assign ins_over = (req_chan.span_length != '0) && (app_sum[PosBits] || doc_sum[PosBits]);
   assign start_piece = '{valid: (orig_ff != '0), from_append: 1'b0, start: '0,
                          size: orig_ff};

   always_comb begin
      idle_next = ST_DUMP;
      unique case (req_chan.action)
         ACT_INSERT: begin
            if ((req_chan.span_length != '0) && !ins_over) idle_next = ST_SCAN;
         end
         ACT_DELETE: begin
            if (hi_c != pos_c) idle_next = ST_SCAN;
         end
         default: idle_next = ST_DUMP;
      endcase
   end

   assign eo = edit_piece(ins_ff, pos_ff, len_ff, lo_ff, hi_ff, app_ff, a_ff,
                          placed_ff, head);
   assign a_in = head.valid ? (a_ff + head.size) : a_ff;
   assign n_in = n_ff + CountBits'(eo.cnt);
   assign n_total = n_in + CountBits'(ins_ff && !eo.placed);
   assign total = 3'(qn_ff) + 3'(eo.cnt);

   always_comb begin
      unique case (qn_ff)
         2'd0: comb = '{eo.p0, eo.p1, eo.p2, piece_type'('0)};
         2'd1: comb = '{q_ff[0], eo.p0, eo.p1, eo.p2};
         default: comb = '{q_ff[0], q_ff[1], eo.p0, eo.p1};
      endcase
   end

   assign dump_emit = (state_ff == ST_DUMP) && (count_ff != '0) && head.valid && out_free;
   assign dump_move = (state_ff == ST_DUMP) && (count_ff != '0) && (!head.valid || out_free);
   assign rsp_load = (state_ff == ST_DUMP) && (((count_ff == '0) && out_free) || dump_emit);

   always_comb begin
      ctl = '{op: CELL_HOLD, phase: step_ff[0]};
      tail = head;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.action == ACT_START)) ctl.op = CELL_LOAD;
         end
         ST_SCAN: ctl.op = CELL_SHIFT;
         ST_REWRITE: begin
            ctl.op = CELL_SHIFT;
            tail = (total != 3'd0) ? comb[0] : '0;
         end
         ST_COMPACT: ctl.op = CELL_SWAP;
         ST_DUMP: begin
            if (dump_move) ctl.op = CELL_SHIFT;
         end
         default: ctl.op = CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < MaxPieces; i++) begin : g_cell
      piece_type left_n;
      piece_type right_n;
      if (i == 0) begin : g_first
         assign left_n = '{valid: 1'b1, from_append: 1'b0, start: '0, size: '0};
      end else begin : g_mid_l
         assign left_n = cell_q[i-1];
      end
      if (i == MaxPieces - 1) begin : g_last
         assign right_n = (ctl.op == CELL_SHIFT) ? tail : piece_type'('0);
      end else begin : g_mid_r
         assign right_n = cell_q[i+1];
      end
      pts_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .odd_pos  (1'(i % 2)),
         .left_in  (left_n),
         .right_in (right_n),
         .load_in  ((i == 0) ? start_piece : piece_type'('0)),
         .piece    (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         doc_ff <= '0;
         app_ff <= '0;
         orig_ff <= '0;
         qn_ff <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) orig_ff <= csr_chan.original_size;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               a_ff <= '0;
               placed_ff <= 1'b0;
               n_ff <= '0;
               qn_ff <= '0;
               emitted_ff <= '0;
               rej_ff <= (req_chan.action == ACT_INSERT) && ins_over;
               ins_ff <= (req_chan.action == ACT_INSERT);
               pos_ff <= pos_c;
               len_ff <= req_chan.span_length;
               lo_ff <= pos_c;
               hi_ff <= hi_c;
               if (req_fire) begin
                  state_ff <= idle_next;
                  if (req_chan.action == ACT_START) begin
                     count_ff <= CountBits'(orig_ff != '0);
                     doc_ff <= orig_ff;
                     app_ff <= '0;
                  end
               end
            end
            ST_SCAN: begin
               n_ff <= n_in;
               if (last_step) begin
                  step_ff <= '0;
                  a_ff <= '0;
                  placed_ff <= 1'b0;
                  if (n_total > CountBits'(MaxPieces)) begin
                     rej_ff <= 1'b1;
                     state_ff <= ST_DUMP;
                  end else begin
                     state_ff <= ST_REWRITE;
                  end
               end else begin
                  a_ff <= a_in;
                  placed_ff <= eo.placed;
                  step_ff <= step_ff + StepBits'(1);
               end
            end
            ST_REWRITE: begin
               a_ff <= a_in;
               placed_ff <= eo.placed;
               q_ff[0] <= comb[1];
               q_ff[1] <= comb[2];
               qn_ff <= (total != 3'd0) ? 2'(total - 3'd1) : 2'd0;
               if (last_step) begin
                  step_ff <= '0;
                  state_ff <= ST_COMPACT;
               end else begin
                  step_ff <= step_ff + StepBits'(1);
               end
            end
            ST_COMPACT: begin
               if (last_step) begin
                  step_ff <= '0;
                  count_ff <= n_ff;
                  if (ins_ff) begin
                     doc_ff <= doc_ff + len_ff;
                     app_ff <= app_ff + len_ff;
                  end else begin
                     doc_ff <= doc_ff - (hi_ff - lo_ff);
                  end
                  state_ff <= ST_DUMP;
               end else begin
                  step_ff <= step_ff + StepBits'(1);
               end
            end
            ST_DUMP: begin
               if (count_ff == '0) begin
                  if (out_free) begin
                     out_piece_ff <= '0;
                     out_total_ff <= doc_ff;
                     out_rej_ff <= rej_ff;
                     out_last_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  if (dump_emit) begin
                     out_piece_ff <= head;
                     out_total_ff <= doc_ff;
                     out_rej_ff <= rej_ff;
                     out_last_ff <= (emitted_ff == count_ff - CountBits'(1));
                     emitted_ff <= emitted_ff + CountBits'(1);
                  end
                  if (dump_move) begin
                     if (last_step) begin
                        step_ff <= '0;
                        state_ff <= ST_IDLE;
                     end else begin
                        step_ff <= step_ff + StepBits'(1);
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.from_append = out_piece_ff.from_append;
   assign rsp_chan.span_start = out_piece_ff.start;
   assign rsp_chan.span_size = out_piece_ff.size;
   assign rsp_chan.entry_valid = out_piece_ff.valid;
   assign rsp_chan.total_length = out_total_ff;
   assign rsp_chan.rejected = out_rej_ff;
   assign rsp_chan.last = out_last_ff;

   `PTS_ASSERT_NEXT(a_queue_drained, clock, reset, (state_ff == ST_REWRITE) && last_step, qn_ff == 2'd0)
   `PTS_ASSERT_IMPLY(a_count_bound, clock, reset, state_ff == ST_DUMP, count_ff <= CountBits'(MaxPieces))
   `PTS_ASSERT_IMPLY(a_emit_bound, clock, reset, dump_emit, emitted_ff < count_ff)
endmodule
`default_nettype wire

@@ test/piece_table_checker.sv @@
// ----------------------------------------------------------------------------
// Piece table span editor checker
// Watches the register, request and result channels, keeps its own copy of
// the piece table, predicts every table dump and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module piece_table_checker (
   input  wire logic clock,
   input  wire logic reset,
   pts_req_if        req,
   pts_rsp_if        rsp,
   pts_csr_if        csr,
   output int        fail_count,
   output int        outstanding
);
   import pts_pkg::*;

   localparam int unsigned PosMask = (1 << PosBits) - 1;

   typedef struct {
      logic    from_append;
      pos_type span_start;
      pos_type span_size;
      logic    entry_valid;
      pos_type total_length;
      logic    rejected;
      logic    last;
   } dump_entry_type;

   dump_entry_type dump_queue[$];

   pos_type     orig_size;
   logic        tbl_src[MaxPieces];
   int unsigned tbl_start[MaxPieces];
   int unsigned tbl_size[MaxPieces];
   int unsigned tbl_count;
   int unsigned doc_len;
   int unsigned append_len;

   logic        new_src[MaxPieces+2];
   int unsigned new_start[MaxPieces+2];
   int unsigned new_size[MaxPieces+2];
   int unsigned new_count;

   assign outstanding = dump_queue.size();

   task automatic add_piece(input logic s, input int unsigned b, input int unsigned z);
      if (new_count < MaxPieces + 2) begin
         new_src[new_count] = s;
         new_start[new_count] = b & PosMask;
         new_size[new_count] = z & PosMask;
         new_count++;
      end
   endtask

   task automatic take_new_table();
      for (int i = 0; i < new_count && i < MaxPieces; i++) begin
         tbl_src[i] = new_src[i];
         tbl_start[i] = new_start[i];
         tbl_size[i] = new_size[i];
      end
      tbl_count = new_count;
   endtask

   task automatic apply_request(input logic [1:0] act, input int unsigned pos,
                                input int unsigned len);
      int unsigned at;
      int unsigned a;
      int unsigned lo;
      int unsigned hi;
      logic        placed;
      logic        refused;
      dump_entry_type e;
      refused = 1'b0;
      new_count = 0;
      at = 0;
      placed = 1'b0;
      case (act)
         ACT_START: begin
            tbl_count = 0;
            if (orig_size != 0) begin
               tbl_src[0] = 1'b0;
               tbl_start[0] = 0;
               tbl_size[0] = orig_size;
               tbl_count = 1;
            end
            doc_len = orig_size;
            append_len = 0;
         end
         ACT_INSERT: begin
            if (len == 0) begin
            end else if (append_len + len > PosMask || doc_len + len > PosMask) begin
               refused = 1'b1;
            end else begin
               if (pos > doc_len) pos = doc_len;
               for (int i = 0; i < tbl_count; i++) begin
                  a = at;
                  at += tbl_size[i];
                  if (!placed && pos < at) begin
                     if (pos == a) begin
                        add_piece(1'b1, append_len, len);
                        add_piece(tbl_src[i], tbl_start[i], tbl_size[i]);
                     end else begin
                        add_piece(tbl_src[i], tbl_start[i], pos - a);
                        add_piece(1'b1, append_len, len);
                        add_piece(tbl_src[i], tbl_start[i] + (pos - a), at - pos);
                     end
                     placed = 1'b1;
                  end else begin
                     add_piece(tbl_src[i], tbl_start[i], tbl_size[i]);
                  end
               end
               if (!placed) add_piece(1'b1, append_len, len);
               if (new_count > MaxPieces) begin
                  refused = 1'b1;
               end else begin
                  take_new_table();
                  append_len = (append_len + len) & PosMask;
                  doc_len = (doc_len + len) & PosMask;
               end
            end
         end
         ACT_DELETE: begin
            lo = (pos > doc_len) ? doc_len : pos;
            hi = lo + len;
            if (hi > doc_len) hi = doc_len;
            if (hi != lo) begin
               for (int i = 0; i < tbl_count; i++) begin
                  a = at;
                  at += tbl_size[i];
                  if (at <= lo || a >= hi) begin
                     add_piece(tbl_src[i], tbl_start[i], tbl_size[i]);
                  end else begin
                     if (a < lo) add_piece(tbl_src[i], tbl_start[i], lo - a);
                     if (at > hi) add_piece(tbl_src[i], tbl_start[i] + (hi - a), at - hi);
                  end
               end
               if (new_count > MaxPieces) begin
                  refused = 1'b1;
               end else begin
                  take_new_table();
                  doc_len = (doc_len - (hi - lo)) & PosMask;
               end
            end
         end
         default: begin
         end
      endcase
      if (tbl_count == 0) begin
         e = '{1'b0, '0, '0, 1'b0, pos_type'(doc_len), refused, 1'b1};
         dump_queue.push_back(e);
      end else begin
         for (int i = 0; i < tbl_count; i++) begin
            e = '{tbl_src[i], pos_type'(tbl_start[i]), pos_type'(tbl_size[i]), 1'b1,
                  pos_type'(doc_len), refused, logic'(i + 1 == tbl_count)};
            dump_queue.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin
      dump_entry_type want;
      if (reset) begin
         orig_size = '0;
         tbl_count = 0;
         doc_len = 0;
         append_len = 0;
         dump_queue.delete();
         fail_count = 0;
      end else begin
         if (csr.valid && csr.ready) orig_size = csr.original_size;
         if (rsp.valid && rsp.ready) begin
            if (dump_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected table entry: append %0d start %0d size %0d",
                           rsp.from_append, rsp.span_start, rsp.span_size);
            end else begin
               want = dump_queue.pop_front();
               if (rsp.from_append !== want.from_append || rsp.span_start !== want.span_start
                   || rsp.span_size !== want.span_size
                   || rsp.entry_valid !== want.entry_valid
                   || rsp.total_length !== want.total_length
                   || rsp.rejected !== want.rejected || rsp.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected app %0d start %0d size %0d ev %0d len %0d ",
                               "rej %0d last %0d, got %0d %0d %0d %0d %0d %0d %0d"},
                              want.from_append, want.span_start, want.span_size,
                              want.entry_valid, want.total_length, want.rejected, want.last,
                              rsp.from_append, rsp.span_start, rsp.span_size,
                              rsp.entry_valid, rsp.total_length, rsp.rejected, rsp.last);
               end
            end
         end
         if (req.valid && req.ready)
            apply_request(req.action, req.position, req.span_length);
      end
   end
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Piece table span editor testbench
// Drives directed and random edit requests in bursts with a stalling result
// side, rewrites the original size between phases, and takes the verdict
// from the checker once every table dump has arrived.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import pts_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   burst_left;
   logic hold_now;

   pts_req_if req ();
   pts_rsp_if rsp ();
   pts_csr_if csr ();

   piece_table_span_editor_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   piece_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr         (csr),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side stall pattern, with one long hold-off in the second random phase
   initial begin
      int cyc;
      cyc = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_now) begin
            rsp.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_now = 1'b0;
         end else begin
            case ((cyc / 300) % 3)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= ($urandom_range(0, 1) == 0);
               default: rsp.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input pos_type pos, input pos_type len);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.action <= act;
      req.position <= pos;
      req.span_length <= len;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (MaxPieces + 10) @(posedge clock);
   endtask

   task automatic write_original_size(input pos_type value);
      drain();
      csr.valid <= 1'b1;
      csr.original_size <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic random_request(input int insert_pct);
      int      r;
      pos_type pos;
      pos_type len;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0: pos = '0;
         1: pos = pos_type'($urandom);
         default: pos = pos_type'($urandom_range(0, 2000));
      endcase
      case ($urandom_range(0, 9))
         0: len = '0;
         1: len = pos_type'($urandom);
         default: len = pos_type'($urandom_range(1, 200));
      endcase
      if (r < 2) send_request(ACT_START, pos, len);
      else if (r < 4) send_request(ACT_NOP, pos, len);
      else if (r < 4 + insert_pct) send_request(ACT_INSERT, pos, len);
      else send_request(ACT_DELETE, pos, len);
   endtask

   initial begin
      pos_type sizes[4];
      int      ins_pct[4];
      reset = 1'b1;
      hold_now = 1'b0;
      burst_left = 0;
      req.valid <= 1'b0;
      req.action <= ACT_START;
      req.position <= '0;
      req.span_length <= '0;
      csr.valid <= 1'b0;
      csr.original_size <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty document, clamping, splits, boundaries, overflow
      write_original_size('0);
      send_request(ACT_START, '0, '0);
      send_request(ACT_INSERT, 20'd5, 20'd3);
      send_request(ACT_INSERT, 20'd0, 20'd0);
      send_request(ACT_INSERT, 20'd1, 20'd2);
      send_request(ACT_INSERT, 20'd0, 20'd4);
      send_request(ACT_INSERT, 20'd4, 20'd1);
      send_request(ACT_DELETE, 20'd2, 20'd3);
      send_request(ACT_DELETE, 20'd100, 20'd5);
      send_request(ACT_NOP, 20'hFFFFF, 20'hFFFFF);
      send_request(ACT_DELETE, 20'd0, 20'hFFFFF);
      send_request(ACT_INSERT, 20'd0, 20'hFFFFF);
      send_request(ACT_INSERT, 20'd0, 20'd1);
      write_original_size(20'hFFFFF);
      send_request(ACT_START, 20'hFFFFF, 20'hFFFFF);
      send_request(ACT_INSERT, 20'hFFFFF, 20'd1);
      send_request(ACT_DELETE, 20'hFFFFE, 20'hFFFFF);
      send_request(ACT_INSERT, 20'd3, 20'd7);
      send_request(ACT_DELETE, 20'd5, 20'd2);
      send_request(ACT_DELETE, 20'hAAAAA, 20'h55555);
      send_request(ACT_INSERT, 20'h55555, 20'hAAAAA);

      sizes = '{20'd1500, pos_type'($urandom_range(1, 3000)), 20'd0, 20'd800};
      ins_pct = '{55, 85, 50, 70};
      for (int ph = 0; ph < 4; ph++) begin
         write_original_size(sizes[ph]);
         send_request(ACT_START, '0, '0);
         if (ph == 1) hold_now = 1'b1;
         for (int i = 0; i < 90; i++) random_request(ins_pct[ph]);
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/pts_pkg.sv
sv/pts_channels.sv
sv/pts_cell.sv
sv/piece_table_span_editor_top.sv
test/piece_table_checker.sv
test/testbench.sv
